/* rtl/core/rcfd_pkg.sv */
// Types and constants shared by the remote-control frame decoder.
// Used by rcfd_capture, rcfd_decode and rc_frame_decoder_top; no dependencies.
package rcfd_pkg;

    localparam int FRAME_BYTES = 18;
    localparam int STORE_BYTES = FRAME_BYTES - 1;
    localparam logic [4:0] LAST_INDEX = 5'(FRAME_BYTES - 1);

    // Configuration register indexes.
    localparam logic [1:0] CFG_HOLD_THRESHOLD = 2'd0;
    localparam logic [1:0] CFG_COMBO_FIRST    = 2'd1;
    localparam logic [1:0] CFG_COMBO_SECOND   = 2'd2;

    localparam logic [7:0]  HOLD_THRESHOLD_RST = 8'd215;
    localparam logic [15:0] COMBO_FIRST_RST    = 16'h0020;
    localparam logic [15:0] COMBO_SECOND_RST   = 16'h0400;
    localparam logic [7:0]  HOLD_MAX           = 8'd255;

    // Input modes.
    localparam logic [1:0] MODE_STOP     = 2'd0;
    localparam logic [1:0] MODE_REMOTE   = 2'd1;
    localparam logic [1:0] MODE_MOUSEKEY = 2'd2;

    // Second switch codes.
    localparam logic [1:0] SW_KEEP     = 2'd0;
    localparam logic [1:0] SW_MOUSEKEY = 2'd1;
    localparam logic [1:0] SW_STOP     = 2'd2;
    localparam logic [1:0] SW_REMOTE   = 2'd3;

    // Key bit positions of the toggled keys.
    localparam int KEY_Z = 11;
    localparam int KEY_X = 12;
    localparam int KEY_F = 9;
    localparam int KEY_R = 8;
    localparam int KEY_C = 13;

    typedef logic [FRAME_BYTES-1:0][7:0] frame_t;

    typedef struct packed {
        logic [7:0]  hold_threshold;
        logic [15:0] combo_first_mask;
        logic [15:0] combo_second_mask;
    } cfg_t;

    typedef struct packed {
        logic last;
    } capture_ctrl_t;

    typedef struct packed {
        logic [43:0]        stick_channels;
        logic [10:0]        wheel_channel;
        logic [3:0]         switches;
        logic signed [15:0] mouse_x;
        logic signed [15:0] mouse_y;
        logic signed [15:0] mouse_z;
        logic [15:0]        mouse_buttons;
        logic [15:0]        key_bits;
        logic [1:0]         input_mode;
        logic [4:0]         toggle_flags;
        logic [1:0]         fire_mode;
        logic               reset_request;
    } result_t;

endpackage

/* rtl/core/rcfd_capture.sv */
// Input register and byte store of the frame decoder.
// Depends on rcfd_pkg for the frame type and the control struct.
module rcfd_capture
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [7:0]             byte_value,
    input  logic [4:0]             byte_index,
    input  logic                   advance,
    output rcfd_pkg::capture_ctrl_t ctrl,
    output rcfd_pkg::frame_t       frame
);

    logic       s1_valid_reg;
    logic       s1_valid_next;
    logic [7:0] s1_byte_reg;
    logic [4:0] s1_index_reg;
    logic [rcfd_pkg::STORE_BYTES-1:0][7:0] store_reg;
    logic       accept;

    assign in_ready      = !s1_valid_reg || advance;
    assign accept        = in_valid && in_ready;
    assign s1_valid_next = accept ? 1'b1 : (advance ? 1'b0 : s1_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_byte_reg  <= byte_value;
            s1_index_reg <= byte_index;
        end
    end

    // Bytes before the last one are kept; the last byte is used straight
    // from the input register while the frame is decoded.
    always_ff @(posedge clk)
    begin
        if (s1_valid_reg && advance && (s1_index_reg < rcfd_pkg::LAST_INDEX))
        begin
            store_reg[s1_index_reg] <= s1_byte_reg;
        end
    end

    assign ctrl.last  = s1_valid_reg && (s1_index_reg == rcfd_pkg::LAST_INDEX);

    always_comb
    begin
        frame[rcfd_pkg::STORE_BYTES-1:0] = store_reg;
        frame[rcfd_pkg::FRAME_BYTES-1]   = s1_byte_reg;
    end

endmodule

/* rtl/core/rcfd_decode.sv */
// Frame unpacking and the mode, combo, toggle and shoot state of the decoder.
// Depends on rcfd_pkg for frame, configuration and result types.
module rcfd_decode
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              commit,
    input  rcfd_pkg::frame_t  frame,
    input  rcfd_pkg::cfg_t    cfg,
    output rcfd_pkg::result_t result
);

    logic [15:0] prev_keys_reg;
    logic [7:0]  prev_right_reg;
    logic [4:0]  toggle_reg;
    logic [1:0]  shoot_reg;
    logic [7:0]  hold_reg;
    logic [1:0]  mode_reg;

    logic [15:0] prev_keys_next;
    logic [7:0]  prev_right_next;
    logic [4:0]  toggle_next;
    logic [1:0]  shoot_next;
    logic [7:0]  hold_next;
    logic [1:0]  mode_next;

    logic [15:0] keys;
    logic [7:0]  right;
    logic [1:0]  sw_second;
    logic [1:0]  mode_sw;
    logic        combo_held;
    logic        reset_req;
    logic [15:0] rising;
    logic [4:0]  flip;

    assign keys      = {frame[15], frame[14]};
    assign right     = frame[13];
    assign sw_second = frame[5][5:4];

    always_comb
    begin
        case (sw_second)
            rcfd_pkg::SW_STOP:     mode_sw = rcfd_pkg::MODE_STOP;
            rcfd_pkg::SW_REMOTE:   mode_sw = rcfd_pkg::MODE_REMOTE;
            rcfd_pkg::SW_MOUSEKEY: mode_sw = rcfd_pkg::MODE_MOUSEKEY;
            default:               mode_sw = mode_reg;
        endcase
    end

    assign combo_held = (|(keys & cfg.combo_first_mask)) && (|(keys & cfg.combo_second_mask));

    always_comb
    begin
        if (!combo_held)
            hold_next = 8'd0;
        else if (hold_reg == rcfd_pkg::HOLD_MAX)
            hold_next = hold_reg;
        else
            hold_next = hold_reg + 8'd1;
    end

    assign reset_req = (hold_next >= cfg.hold_threshold);
    assign mode_next = reset_req ? rcfd_pkg::MODE_STOP : mode_sw;

    assign rising = keys & ~prev_keys_reg;
    assign flip   = {rising[rcfd_pkg::KEY_C], rising[rcfd_pkg::KEY_R], rising[rcfd_pkg::KEY_F],
                     rising[rcfd_pkg::KEY_X], rising[rcfd_pkg::KEY_Z]};

    // Toggles and shoot mode only move outside stop mode.
    always_comb
    begin
        toggle_next = toggle_reg;
        shoot_next  = shoot_reg;
        if (mode_next != rcfd_pkg::MODE_STOP)
        begin
            toggle_next = toggle_reg ^ flip;
            if ((right != 8'd0) && (prev_right_reg == 8'd0))
                shoot_next = shoot_reg + 2'd1;
        end
    end

    assign prev_keys_next  = keys;
    assign prev_right_next = right;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_keys_reg  <= '0;
            prev_right_reg <= '0;
            toggle_reg     <= '0;
            shoot_reg      <= '0;
            hold_reg       <= '0;
            mode_reg       <= rcfd_pkg::MODE_STOP;
        end
        else if (commit)
        begin
            prev_keys_reg  <= prev_keys_next;
            prev_right_reg <= prev_right_next;
            toggle_reg     <= toggle_next;
            shoot_reg      <= shoot_next;
            hold_reg       <= hold_next;
            mode_reg       <= mode_next;
        end
    end

    always_comb
    begin
        result.stick_channels = {frame[5][3:0], frame[4][7:1],
                                 frame[4][0], frame[3], frame[2][7:6],
                                 frame[2][5:0], frame[1][7:3],
                                 frame[1][2:0], frame[0]};
        result.wheel_channel  = {frame[17][2:0], frame[16]};
        result.switches       = frame[5][7:4];
        result.mouse_x        = $signed({frame[7], frame[6]});
        result.mouse_y        = $signed({frame[9], frame[8]});
        result.mouse_z        = $signed({frame[11], frame[10]});
        result.mouse_buttons  = {frame[13], frame[12]};
        result.key_bits       = keys;
        result.input_mode     = mode_next;
        result.toggle_flags   = toggle_next;
        result.fire_mode      = shoot_next;
        result.reset_request  = reset_req;
    end

endmodule

/* rtl/core/rc_frame_decoder_top.sv */
// Top level of the remote-control frame decoder: configuration registers,
// flow control and the result register. Depends on rcfd_pkg, rcfd_capture, rcfd_decode.
//
// Usage: frame bytes enter on the request channel (in_valid, in_ready,
// byte_value, byte_index), one byte per request, each with its position
// 0..17 in the frame. Positions 0..16 are only stored. Position 17
// completes the frame; its request produces exactly one decoded result on
// the out_valid/out_ready channel. Indexes of 18 or more are dropped.
// Every byte must have been written once before its frame is completed.
//
// A completing byte is decoded while it sits in the input register and lands in
// the result register, which drives the outputs, once that register has room.
// Throughput: one byte per cycle while no completing byte waits on a stalled
// result, set by the combinational decode between the input register and the
// result register.
//
// Reset (rst_n low, asynchronous) empties both registers, returns the mode
// to stop, clears the combo counter, toggles, shoot mode and key history,
// and loads the default configuration. Stored frame bytes are not cleared.
//
// When the receiver stalls, the result stays in the output register. Partial
// bytes keep flowing into the store; a completing byte waits in the input
// register until the pending result is taken. The user must write configuration
// via cfg_write/cfg_index/cfg_data only while the block is idle; it is not enforced.
module rc_frame_decoder_top
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_write,
    input  logic [1:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [7:0]         byte_value,
    input  logic [4:0]         byte_index,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [43:0]        stick_channels,
    output logic [10:0]        wheel_channel,
    output logic [3:0]         switches,
    output logic signed [15:0] mouse_x,
    output logic signed [15:0] mouse_y,
    output logic signed [15:0] mouse_z,
    output logic [15:0]        mouse_buttons,
    output logic [15:0]        key_bits,
    output logic [1:0]         input_mode,
    output logic [4:0]         toggle_flags,
    output logic [1:0]         fire_mode,
    output logic               reset_request
);

    rcfd_pkg::cfg_t          cfg_reg;
    rcfd_pkg::capture_ctrl_t ctrl;
    rcfd_pkg::frame_t        frame;
    rcfd_pkg::result_t       decoded;
    rcfd_pkg::result_t       result_reg;
    logic                    out_valid_reg;
    logic                    out_valid_next;
    logic                    out_free;
    logic                    advance;
    logic                    commit;

    // Configuration registers; index 3 hits nothing.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.hold_threshold    <= rcfd_pkg::HOLD_THRESHOLD_RST;
            cfg_reg.combo_first_mask  <= rcfd_pkg::COMBO_FIRST_RST;
            cfg_reg.combo_second_mask <= rcfd_pkg::COMBO_SECOND_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                rcfd_pkg::CFG_HOLD_THRESHOLD: cfg_reg.hold_threshold    <= cfg_data[7:0];
                rcfd_pkg::CFG_COMBO_FIRST:    cfg_reg.combo_first_mask  <= cfg_data;
                rcfd_pkg::CFG_COMBO_SECOND:   cfg_reg.combo_second_mask <= cfg_data;
                default:                      ;
            endcase
        end
    end

    // The output register can take a new result when it is empty or being
    // drained in this cycle. Only a completing byte needs that room.
    assign out_free = !out_valid_reg || out_ready;
    assign advance  = !ctrl.last || out_free;
    assign commit   = ctrl.last && out_free;

    rcfd_capture u_capture
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .byte_value (byte_value),
        .byte_index (byte_index),
        .advance    (advance),
        .ctrl       (ctrl),
        .frame      (frame)
    );

    rcfd_decode u_decode
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .commit (commit),
        .frame  (frame),
        .cfg    (cfg_reg),
        .result (decoded)
    );

    assign out_valid_next = commit ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (commit)
        begin
            result_reg <= decoded;
        end
    end

    assign out_valid      = out_valid_reg;
    assign stick_channels = result_reg.stick_channels;
    assign wheel_channel  = result_reg.wheel_channel;
    assign switches       = result_reg.switches;
    assign mouse_x        = result_reg.mouse_x;
    assign mouse_y        = result_reg.mouse_y;
    assign mouse_z        = result_reg.mouse_z;
    assign mouse_buttons  = result_reg.mouse_buttons;
    assign key_bits       = result_reg.key_bits;
    assign input_mode     = result_reg.input_mode;
    assign toggle_flags   = result_reg.toggle_flags;
    assign fire_mode      = result_reg.fire_mode;
    assign reset_request  = result_reg.reset_request;

endmodule

/* tb/rc_frame_decoder_checker.sv */
// Scoreboard for the remote-control frame decoder: mirrors the frame store and the
// mode, combo, toggle and shoot state, predicts each decoded result and compares it.
// Depends on rcfd_pkg for the result layout, register indexes, modes and key positions.
module rc_frame_decoder_checker
    import rcfd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_write,
    input  logic [1:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    input  logic               in_valid,
    input  logic               in_ready,
    input  logic [7:0]         byte_value,
    input  logic [4:0]         byte_index,
    input  logic               out_valid,
    input  logic               out_ready,
    input  logic [43:0]        stick_channels,
    input  logic [10:0]        wheel_channel,
    input  logic [3:0]         switches,
    input  logic signed [15:0] mouse_x,
    input  logic signed [15:0] mouse_y,
    input  logic signed [15:0] mouse_z,
    input  logic [15:0]        mouse_buttons,
    input  logic [15:0]        key_bits,
    input  logic [1:0]         input_mode,
    input  logic [4:0]         toggle_flags,
    input  logic [1:0]         fire_mode,
    input  logic               reset_request,
    output int                 mismatch_count,
    output int                 pending_results
);
    timeunit 1ns;
    timeprecision 1ps;

    // Mirrored state of the decoder.
    frame_t      frame_bytes;
    logic [15:0] last_keys;
    logic [7:0]  last_right;
    logic [4:0]  toggles;
    logic [1:0]  shoot;
    logic [7:0]  hold_count;
    logic [1:0]  mode;
    cfg_t        cfg;

    result_t     decoded_q[$];
    result_t     want;

    initial mismatch_count = 0;

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] exp_val);
        $display("%0t ns: mismatch on %s: got %0h, expected %0h",
                 $realtime, what, got, exp_val);
        mismatch_count++;
    endtask

    task automatic check_field(input string what, input logic [63:0] got,
                               input logic [63:0] exp_val);
        if (got !== exp_val)
            report_mismatch(what, got, exp_val);
    endtask

    // Decodes the stored frame, advances the mode and key state, and queues the result.
    task automatic decode_stored_frame();
        result_t     r;
        logic [15:0] keys;
        logic [15:0] rise;
        logic [7:0]  right;

        keys  = {frame_bytes[15], frame_bytes[14]};
        right = frame_bytes[13];

        case (frame_bytes[5][5:4])
            SW_STOP:     mode = MODE_STOP;
            SW_REMOTE:   mode = MODE_REMOTE;
            SW_MOUSEKEY: mode = MODE_MOUSEKEY;
            default:     ;
        endcase

        if ((keys & cfg.combo_first_mask) != 16'd0 && (keys & cfg.combo_second_mask) != 16'd0)
        begin
            if (hold_count != HOLD_MAX)
                hold_count = hold_count + 8'd1;
        end
        else
        begin
            hold_count = 8'd0;
        end

        r.reset_request = 1'b0;
        if (hold_count >= cfg.hold_threshold)
        begin
            mode = MODE_STOP;
            r.reset_request = 1'b1;
        end

        if (mode != MODE_STOP)
        begin
            rise = keys & ~last_keys;
            toggles = toggles ^ {rise[KEY_C], rise[KEY_R], rise[KEY_F], rise[KEY_X], rise[KEY_Z]};
            if (right != 8'd0 && last_right == 8'd0)
                shoot = shoot + 2'd1;
        end
        last_keys  = keys;
        last_right = right;

        r.stick_channels = {11'({frame_bytes[5], frame_bytes[4]} >> 1),
                            11'({frame_bytes[4], frame_bytes[3], frame_bytes[2]} >> 6),
                            11'({frame_bytes[2], frame_bytes[1]} >> 3),
                            11'({frame_bytes[1], frame_bytes[0]})};
        r.wheel_channel  = 11'({frame_bytes[17], frame_bytes[16]});
        r.switches       = frame_bytes[5][7:4];
        r.mouse_x        = {frame_bytes[7], frame_bytes[6]};
        r.mouse_y        = {frame_bytes[9], frame_bytes[8]};
        r.mouse_z        = {frame_bytes[11], frame_bytes[10]};
        r.mouse_buttons  = {frame_bytes[13], frame_bytes[12]};
        r.key_bits       = keys;
        r.input_mode     = mode;
        r.toggle_flags   = toggles;
        r.fire_mode      = shoot;
        decoded_q.push_back(r);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            // The frame store is not cleared by reset, so its mirror is left alone too.
            last_keys  = 16'd0;
            last_right = 8'd0;
            toggles    = 5'd0;
            shoot      = 2'd0;
            hold_count = 8'd0;
            mode       = MODE_STOP;
            cfg.hold_threshold    = HOLD_THRESHOLD_RST;
            cfg.combo_first_mask  = COMBO_FIRST_RST;
            cfg.combo_second_mask = COMBO_SECOND_RST;
            decoded_q.delete();
            pending_results <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (decoded_q.size() == 0)
                begin
                    report_mismatch("result with nothing expected", 64'd1, 64'd0);
                end
                else
                begin
                    want = decoded_q.pop_front();
                    check_field("stick_channels", stick_channels, want.stick_channels);
                    check_field("wheel_channel", wheel_channel, want.wheel_channel);
                    check_field("switches", switches, want.switches);
                    check_field("mouse_x", $unsigned(mouse_x), $unsigned(want.mouse_x));
                    check_field("mouse_y", $unsigned(mouse_y), $unsigned(want.mouse_y));
                    check_field("mouse_z", $unsigned(mouse_z), $unsigned(want.mouse_z));
                    check_field("mouse_buttons", mouse_buttons, want.mouse_buttons);
                    check_field("key_bits", key_bits, want.key_bits);
                    check_field("input_mode", input_mode, want.input_mode);
                    check_field("toggle_flags", toggle_flags, want.toggle_flags);
                    check_field("fire_mode", fire_mode, want.fire_mode);
                    check_field("reset_request", reset_request, want.reset_request);
                end
            end

            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_HOLD_THRESHOLD: cfg.hold_threshold    = cfg_data[7:0];
                    CFG_COMBO_FIRST:    cfg.combo_first_mask  = cfg_data;
                    CFG_COMBO_SECOND:   cfg.combo_second_mask = cfg_data;
                    default:            ;
                endcase
            end

            if (in_valid && in_ready && byte_index < FRAME_BYTES)
            begin
                frame_bytes[byte_index] = byte_value;
                if (byte_index == LAST_INDEX)
                    decode_stored_frame();
            end

            pending_results <= decoded_q.size();
        end
    end

endmodule

/* tb/tb_rc_frame_decoder_top.sv */
// Testbench top for rc_frame_decoder_top: clock, reset, byte requests, register writes
// and back-pressure. Depends on rcfd_pkg and rc_frame_decoder_checker for all checking.
module tb_rc_frame_decoder_top;
    timeunit 1ns;
    timeprecision 1ps;

    import rcfd_pkg::*;

    // A generous bound: several hundred byte requests, each possibly delayed by
    // sender gaps and by waiting on a stalled result.
    localparam int CYCLE_LIMIT = 200000;
    localparam int RANDOM_ITEMS_PER_PHASE = 85;

    // Register index past the end of the list; the block must ignore writes to it.
    localparam logic [1:0] CFG_UNUSED = 2'd3;

    logic               clk;
    logic               rst_n = 1'b0;
    logic               cfg_write = 1'b0;
    logic [1:0]         cfg_index = CFG_HOLD_THRESHOLD;
    logic [15:0]        cfg_data = 16'd0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic [7:0]         byte_value = 8'd0;
    logic [4:0]         byte_index = 5'd0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [43:0]        stick_channels;
    logic [10:0]        wheel_channel;
    logic [3:0]         switches;
    logic signed [15:0] mouse_x;
    logic signed [15:0] mouse_y;
    logic signed [15:0] mouse_z;
    logic [15:0]        mouse_buttons;
    logic [15:0]        key_bits;
    logic [1:0]         input_mode;
    logic [4:0]         toggle_flags;
    logic [1:0]         fire_mode;
    logic               reset_request;

    int mismatch_count;
    int pending_results;
    int cycle_count = 0;

    // Percent of cycles in which the sender holds back a request, and in which the
    // receiver refuses a result. Both are changed between phases of the run.
    int send_idle_pct = 0;
    int stall_pct = 0;

    // Combo masks last written, so that random keys can hit the combo on purpose.
    logic [15:0] cur_first = COMBO_FIRST_RST;
    logic [15:0] cur_second = COMBO_SECOND_RST;

    logic [7:0] frame_buf [FRAME_BYTES];

    rc_frame_decoder_top DUT
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .byte_value     (byte_value),
        .byte_index     (byte_index),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .stick_channels (stick_channels),
        .wheel_channel  (wheel_channel),
        .switches       (switches),
        .mouse_x        (mouse_x),
        .mouse_y        (mouse_y),
        .mouse_z        (mouse_z),
        .mouse_buttons  (mouse_buttons),
        .key_bits       (key_bits),
        .input_mode     (input_mode),
        .toggle_flags   (toggle_flags),
        .fire_mode      (fire_mode),
        .reset_request  (reset_request)
    );

    rc_frame_decoder_checker u_checker
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_write       (cfg_write),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .byte_value      (byte_value),
        .byte_index      (byte_index),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .stick_channels  (stick_channels),
        .wheel_channel   (wheel_channel),
        .switches        (switches),
        .mouse_x         (mouse_x),
        .mouse_y         (mouse_y),
        .mouse_z         (mouse_z),
        .mouse_buttons   (mouse_buttons),
        .key_bits        (key_bits),
        .input_mode      (input_mode),
        .toggle_flags    (toggle_flags),
        .fire_mode       (fire_mode),
        .reset_request   (reset_request),
        .mismatch_count  (mismatch_count),
        .pending_results (pending_results)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // The receiver decides afresh at every edge whether it takes a result.
    always @(posedge clk)
        out_ready <= ($urandom_range(0, 99) >= stall_pct);

    // Watchdog: a hung handshake or a result that never arrives ends the run here.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb_rc_frame_decoder_top: FAIL");
            $finish;
        end
    end

    // Issues one byte request. Valid stays high from the moment it is raised until
    // the edge that accepts the request; the caller either keeps it high for the
    // next request or lowers it.
    task automatic send_byte(input logic [7:0] value, input logic [4:0] index);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        byte_value <= value;
        byte_index <= index;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic send_frame_buf();
        for (int i = 0; i < FRAME_BYTES; i++)
            send_byte(frame_buf[i], 5'(i));
    endtask

    // Lets every predicted result drain, then lets the two-stage pipeline settle
    // so that a byte which produces no result has also passed through.
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_results != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Drives one register write for a single edge. The caller lowers cfg_write
    // after the last write of a batch, so it never gets two updates in one step.
    task automatic write_reg(input logic [1:0] index, input logic [15:0] data);
        cfg_write <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        @(posedge clk);
    endtask

    // The upper byte of the threshold write is random; only the low byte counts.
    task automatic program_cfg(input logic [7:0] threshold, input logic [15:0] first_mask,
                               input logic [15:0] second_mask);
        write_reg(CFG_HOLD_THRESHOLD, {8'($urandom), threshold});
        write_reg(CFG_COMBO_FIRST, first_mask);
        write_reg(CFG_COMBO_SECOND, second_mask);
        cfg_write  <= 1'b0;
        cur_first  = first_mask;
        cur_second = second_mask;
    endtask

    // Key patterns: anything, the combo plus a key of bits 8..13, nothing, or one such key.
    function automatic logic [15:0] pick_keys();
        logic [15:0] k;
        case ($urandom_range(0, 3))
            0:       k = 16'($urandom);
            1:       k = cur_first | cur_second | (16'd1 << $urandom_range(KEY_R, KEY_C));
            2:       k = 16'd0;
            default: k = 16'd1 << $urandom_range(KEY_R, KEY_C);
        endcase
        return k;
    endfunction

    // Right button released half of the time, so that presses show up as edges.
    function automatic logic [7:0] pick_right();
        return $urandom_range(0, 1) ? 8'd0 : 8'($urandom_range(1, 255));
    endfunction

    // Mix of whole frames in order, partial updates of the control bytes ending in
    // the completing byte, and stray bytes at any index including past the frame.
    task automatic run_random_phase(input int quota);
        int          sent;
        int          kind;
        logic [4:0]  stray_index;
        logic [15:0] keys;

        sent = 0;
        while (sent < quota)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 55)
            begin
                for (int i = 0; i < FRAME_BYTES; i++)
                    frame_buf[i] = 8'($urandom);
                keys = pick_keys();
                frame_buf[13] = pick_right();
                frame_buf[14] = keys[7:0];
                frame_buf[15] = keys[15:8];
                send_frame_buf();
                sent += FRAME_BYTES;
            end
            else if (kind < 85)
            begin
                // Bytes not rewritten keep their stored value, so a held combo
                // or a held key survives across several frames.
                if ($urandom_range(0, 1))
                begin
                    send_byte(8'($urandom), 5'd5);
                    sent++;
                end
                if ($urandom_range(0, 1))
                begin
                    send_byte(pick_right(), 5'd13);
                    sent++;
                end
                if ($urandom_range(0, 1))
                begin
                    keys = pick_keys();
                    send_byte(keys[7:0], 5'd14);
                    send_byte(keys[15:8], 5'd15);
                    sent += 2;
                end
                if ($urandom_range(0, 2) == 0)
                begin
                    send_byte(8'($urandom), 5'($urandom_range(0, FRAME_BYTES - 2)));
                    sent++;
                end
                send_byte(8'($urandom), LAST_INDEX);
                sent++;
            end
            else
            begin
                stray_index = 5'($urandom_range(0, 31));
                send_byte(8'($urandom), stray_index);
                if (stray_index < FRAME_BYTES)
                    sent++;
            end
        end
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part with default registers and no idling.
        // First frame: every position written, alternating 0x00 and 0xFF, so each
        // field sees both extremes. The second switch reads 3, giving remote mode,
        // and keys 0xFF00 give rising edges on all five toggled keys and the right
        // button byte starts a press.
        for (int i = 0; i < FRAME_BYTES; i++)
            frame_buf[i] = (i % 2 == 1) ? 8'hFF : 8'h00;
        send_frame_buf();

        // Indexes past the frame must be dropped without any effect.
        send_byte(8'h55, 5'd18);
        send_byte(8'hAA, 5'd31);

        // Second switch at zero keeps remote mode; keys released, right button held.
        send_byte(8'h00, 5'd5);
        send_byte(8'h00, 5'd15);
        send_byte(8'h3C, LAST_INDEX);

        // Stop mode: key presses and a right-button release must not toggle anything,
        // though the key history still follows the frame.
        send_byte(8'h20, 5'd5);
        send_byte(8'h00, 5'd13);
        send_byte(8'hFF, 5'd15);
        send_byte(8'hC3, LAST_INDEX);

        // Mouse-and-keys mode: release everything, then press Z alone and the right
        // button, which toggles one flag and advances the shoot mode.
        send_byte(8'h10, 5'd5);
        send_byte(8'h00, 5'd15);
        send_byte(8'h81, LAST_INDEX);
        send_byte(8'h08, 5'd15);
        send_byte(8'h01, 5'd13);
        send_byte(8'h7E, LAST_INDEX);

        // A two-frame threshold: holding control and G forces stop mode and raises
        // the reset request from the second frame on, then releasing clears it.
        wait_idle();
        program_cfg(8'd2, 16'h0020, 16'h0400);
        send_byte(8'h20, 5'd14);
        send_byte(8'h04, 5'd15);
        repeat (3) send_byte(8'($urandom), LAST_INDEX);
        send_byte(8'h00, 5'd14);
        send_byte(8'($urandom), LAST_INDEX);

        // A zero threshold requests a reset on every frame, combo or not.
        wait_idle();
        program_cfg(8'd0, 16'hFFFF, 16'h0000);
        send_byte(8'($urandom), LAST_INDEX);

        // An empty first mask can never count as held, even with every key down.
        wait_idle();
        program_cfg(8'd1, 16'h0000, 16'hFFFF);
        send_byte(8'hFF, 5'd14);
        send_byte(8'hFF, 5'd15);
        send_byte(8'($urandom), LAST_INDEX);

        // A write to the unused register index must change nothing.
        wait_idle();
        write_reg(CFG_UNUSED, 16'($urandom));
        cfg_write <= 1'b0;
        send_byte(8'($urandom), LAST_INDEX);

        // Largest threshold: hold the combo long enough for the counter to reach the
        // threshold and then saturate, with light idling on both sides.
        wait_idle();
        program_cfg(8'd255, 16'hFFFF, 16'hFFFF);
        send_idle_pct = 17;
        stall_pct = 17;
        repeat (260) send_byte(8'($urandom), LAST_INDEX);
        send_byte(8'h00, 5'd14);
        send_byte(8'h00, 5'd15);
        send_byte(8'($urandom), LAST_INDEX);

        // Random part: four idling patterns, each with its own register setting.
        for (int p = 0; p < 4; p++)
        begin
            wait_idle();
            case (p)
                0:
                begin
                    send_idle_pct = 0;
                    stall_pct = 0;
                    program_cfg(8'd1, 16'hFFFF, 16'hFFFF);
                end
                1:
                begin
                    send_idle_pct = 74;
                    stall_pct = 0;
                    program_cfg(8'd4, 16'd1 << $urandom_range(0, 15),
                                16'd1 << $urandom_range(0, 15));
                end
                2:
                begin
                    send_idle_pct = 0;
                    stall_pct = 74;
                    program_cfg(8'($urandom_range(2, 10)), 16'($urandom), 16'($urandom));
                end
                default:
                begin
                    send_idle_pct = 17;
                    stall_pct = 17;
                    program_cfg(HOLD_THRESHOLD_RST, COMBO_FIRST_RST, COMBO_SECOND_RST);
                end
            endcase
            run_random_phase(RANDOM_ITEMS_PER_PHASE);
        end

        // Everything sent; let the last results drain before the verdict.
        wait_idle();
        if (mismatch_count == 0)
            $display("tb_rc_frame_decoder_top: PASS");
        else
            $display("tb_rc_frame_decoder_top: FAIL");
        $finish;
    end

endmodule

/* files.f */
rtl/core/rcfd_pkg.sv
rtl/core/rcfd_capture.sv
rtl/core/rcfd_decode.sv
rtl/core/rc_frame_decoder_top.sv
tb/rc_frame_decoder_checker.sv
tb/tb_rc_frame_decoder_top.sv
